@@ rtl/mec_pkg.sv @@
// shared types and constants for the mandelbrot escape counter
package mec_pkg;

	// fixed point format of c and z: signed, 32 bits, FRAC_BITS fraction bits
	localparam int unsigned FRAC_BITS   = 28;
	localparam int unsigned COORD_RANGE = 4096;
	localparam int unsigned MAX_COUNT   = 255;

	localparam int unsigned VAL_W   = 32;
	localparam int unsigned PIX_W   = 12;
	localparam int unsigned STEP_W  = 31;
	localparam int unsigned COUNT_W = 9;

	// config register map, index into the register list
	localparam int unsigned CFG_ADDR_W = 4;
	localparam logic [1:0] REG_CORNER_REAL = 2'd0;
	localparam logic [1:0] REG_CORNER_IMAG = 2'd1;
	localparam logic [1:0] REG_PIXEL_STEP  = 2'd2;

	localparam logic [31:0] CORNER_REAL_RST = 32'(-88583700);
	localparam logic [31:0] CORNER_IMAG_RST = 32'(-233538847);
	localparam logic [30:0] PIXEL_STEP_RST  = 31'd111848;

	// point of the complex plane handed from front to back
	typedef struct packed {
		logic signed [VAL_W-1:0] c_im;
		logic signed [VAL_W-1:0] c_re;
	} mec_coord_t;

endpackage

@@ rtl/mec_queue.sv @@
// short flip-flop queue between the coordinate front and the iteration core
module mec_queue #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    fill_q;

	assign full      = (fill_q == FULL_CNT);
	assign not_empty = (fill_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

endmodule

@@ rtl/mec_front.sv @@
// config registers and pixel to complex-plane coordinate mapping
module mec_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mec_pkg::CFG_ADDR_W-1:0]      paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [23:0]                         s_tdata,   // pixel_x, pixel_y
	output logic                                push,
	output mec_pkg::mec_coord_t                 push_data,
	input  logic                                full
);

	localparam int unsigned PW = mec_pkg::PIX_W;
	localparam int unsigned RECIP_SHIFT = 28;
	localparam logic [28:0] COORD_RECIP = 29'(((64'd1 << RECIP_SHIFT)
		+ 64'(mec_pkg::COORD_RANGE) - 64'd1) / 64'(mec_pkg::COORD_RANGE));

	logic [31:0] corner_real_q;
	logic [31:0] corner_imag_q;
	logic [30:0] pixel_step_q;
	logic        wr_en;
	logic [1:0]  reg_idx;

	logic [PW-1:0] px;
	logic [PW-1:0] py;
	logic [42:0]   off_x;
	logic [42:0]   off_y;

	// pixel index modulo the coordinate range, by reciprocal multiply
	function automatic logic [PW-1:0] coord_wrap(input logic [PW-1:0] p);
		logic [40:0]   prod;
		logic [PW-1:0] quo;
		if (mec_pkg::COORD_RANGE >= (1 << PW)) begin
			return p;
		end else begin
			prod = 41'(p) * 41'(COORD_RECIP);
			quo  = PW'(prod >> RECIP_SHIFT);
			return p - PW'(32'(quo) * 32'(mec_pkg::COORD_RANGE));
		end
	endfunction

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	always_comb begin
		case (reg_idx)
			mec_pkg::REG_CORNER_REAL: prdata = corner_real_q;
			mec_pkg::REG_CORNER_IMAG: prdata = corner_imag_q;
			mec_pkg::REG_PIXEL_STEP:  prdata = {1'b0, pixel_step_q};
			default:                  prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_real_q <= mec_pkg::CORNER_REAL_RST;
			corner_imag_q <= mec_pkg::CORNER_IMAG_RST;
			pixel_step_q  <= mec_pkg::PIXEL_STEP_RST;
		end else if (wr_en) begin
			case (reg_idx)
				mec_pkg::REG_CORNER_REAL: corner_real_q <= pwdata;
				mec_pkg::REG_CORNER_IMAG: corner_imag_q <= pwdata;
				mec_pkg::REG_PIXEL_STEP:  pixel_step_q  <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	// c = corner + index * step, wrapped to 32 bits
	assign px    = coord_wrap(s_tdata[11:0]);
	assign py    = coord_wrap(s_tdata[23:12]);
	assign off_x = 43'(px) * 43'(pixel_step_q);
	assign off_y = 43'(py) * 43'(pixel_step_q);

	assign s_tready       = !full;
	assign push           = s_tvalid && !full;
	assign push_data.c_re = signed'(corner_real_q + off_x[31:0]);
	assign push_data.c_im = signed'(corner_imag_q + off_y[31:0]);

endmodule

@@ rtl/mec_core.sv @@
// escape-time iteration engine with registered result word
module mec_core #(
	parameter int unsigned MAX_COUNT = mec_pkg::MAX_COUNT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	input  mec_pkg::mec_coord_t               q_data,
	output logic                              q_pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [15:0]                       m_tdata    // iteration_count
);

	localparam int unsigned F  = mec_pkg::FRAC_BITS;
	localparam int unsigned CW = $clog2(MAX_COUNT + 1);
	localparam int unsigned OW = mec_pkg::COUNT_W;
	localparam bit HAS_THR = (2 * F + 2 < 64);
	localparam logic [64:0] ESC_THR = HAS_THR ? (65'd4 << (2 * F)) : '1;
	localparam logic [CW-1:0] LAST_CNT = CW'(MAX_COUNT - 1);
	localparam logic [OW-1:0] NO_ESC = OW'(MAX_COUNT + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;
	localparam logic [1:0] ST_HOLD = 2'd3;

	logic [1:0]        state_q;
	logic [CW-1:0]     cnt_q;
	logic signed [31:0] a_q, b_q, cr_q, ci_q;
	logic signed [63:0] sa_q, sb_q, ab_q;
	logic [OW-1:0]     res_q;
	logic              out_valid_q;
	logic [OW-1:0]     out_cnt_q;

	logic signed [63:0] sa_d, sb_d, ab_d;
	logic [64:0]        mag;
	logic               escape;
	logic signed [63:0] diff;
	logic signed [63:0] re_sh, im_sh;
	logic [31:0]        a_next, b_next;
	logic [OW-1:0]      esc_cnt;
	logic               out_free;
	logic               finish;
	logic [OW-1:0]      fin_cnt;
	logic               load_out;
	logic [OW-1:0]      load_cnt;

	assign sa_d = a_q * a_q;
	assign sb_d = b_q * b_q;
	assign ab_d = a_q * b_q;

	// squares are non-negative, so the sum fits in 64 bits unsigned
	assign mag    = {1'b0, sa_q} + {1'b0, sb_q};
	assign escape = HAS_THR && (mag > ESC_THR);
	assign diff   = sa_q - sb_q;
	assign re_sh  = diff >>> F;
	assign im_sh  = ab_q >>> (F - 1);
	assign a_next = re_sh[31:0] + cr_q;
	assign b_next = im_sh[31:0] + ci_q;
	assign esc_cnt = OW'(32'(cnt_q) + 32'd1);

	assign out_free = !out_valid_q || m_tready;
	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign finish   = (state_q == ST_UPD) && (escape || cnt_q == LAST_CNT);
	assign fin_cnt  = escape ? esc_cnt : NO_ESC;

	always_comb begin
		load_out = 1'b0;
		load_cnt = fin_cnt;
		if (finish && out_free) begin
			load_out = 1'b1;
		end else if (state_q == ST_HOLD && out_free) begin
			load_out = 1'b1;
			load_cnt = res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:  state_q <= ST_UPD;
				ST_UPD: begin
					if (finish) begin
						state_q <= out_free ? ST_IDLE : ST_HOLD;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_cnt_q <= load_cnt;
		end
		case (state_q)
			ST_IDLE: begin
				a_q   <= q_data.c_re;
				b_q   <= q_data.c_im;
				cr_q  <= q_data.c_re;
				ci_q  <= q_data.c_im;
				cnt_q <= '0;
			end
			ST_MUL: begin
				sa_q <= sa_d;
				sb_q <= sb_d;
				ab_q <= ab_d;
			end
			ST_UPD: begin
				a_q   <= signed'(a_next);
				b_q   <= signed'(b_next);
				cnt_q <= cnt_q + CW'(1);
				res_q <= fin_cnt;
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(16 - OW)'(0), out_cnt_q};

endmodule

@@ rtl/mandelbrot_escape_count.sv @@
// top level of the mandelbrot escape-time counter
//
//  channel  | direction | word / register
//  ---------+-----------+------------------------------------------------
//  s_*      | in        | tdata[11:0] pixel_x, tdata[23:12] pixel_y
//  m_*      | out       | tdata[8:0] iteration_count, upper bits zero
//  apb      | in / out  | 0x0 corner_real, 0x4 corner_imag, 0x8 pixel_step
//
// the result word of a pixel that escapes at count k is k, MAX_COUNT + 1
// if it never escapes; each iteration runs the 32x32 square/product unit,
// then the escape compare and z update, and the core takes a pixel off the
// queue only when idle, so not before the last result is loaded
// reset loads the default corner and step and empties the queue
// the front keeps taking pixels into the two-entry queue while the core
// iterates, and the core finishes into a result register so a stalled
// output only blocks it once the next result is also ready
module mandelbrot_escape_count #(
	parameter int unsigned MAX_COUNT = mec_pkg::MAX_COUNT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// config port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mec_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	// pixel stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [23:0]                    s_tdata,   // pixel_x, pixel_y
	// result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [15:0]                    m_tdata    // iteration_count
);

	localparam int unsigned QW = $bits(mec_pkg::mec_coord_t);

	logic                push;
	mec_pkg::mec_coord_t push_data;
	logic                full;
	logic                q_pop;
	logic [QW-1:0]       q_word;
	mec_pkg::mec_coord_t q_data;
	logic                q_valid;

	// register file and c = corner + index * step
	mec_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	// decouples pixel intake from the iteration loop
	mec_queue #(
		.WIDTH (QW),
		.DEPTH (2)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (QW'(push_data)),
		.full      (full),
		.pop       (q_pop),
		.pop_data  (q_word),
		.not_empty (q_valid)
	);

	assign q_data = mec_pkg::mec_coord_t'(q_word);

	// z = z^2 + c loop and result word
	mec_core #(
		.MAX_COUNT (MAX_COUNT)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
